FILE: design/gpt_pkg.sv
package gpt_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CHANNELS    = 4;

    typedef logic [COUNT_WIDTH-1:0] cnt_t;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // register map
    localparam logic [3:0] REG_CTRL   = 4'd0;
    localparam logic [3:0] REG_IRQ_EN = 4'd1;
    localparam logic [3:0] REG_STATUS = 4'd2;
    localparam logic [3:0] REG_EVENT  = 4'd3;
    localparam logic [3:0] REG_MODE0  = 4'd4;
    localparam logic [3:0] REG_MODE1  = 4'd5;
    localparam logic [3:0] REG_CHEN   = 4'd6;
    localparam logic [3:0] REG_COUNT  = 4'd7;
    localparam logic [3:0] REG_PSC    = 4'd8;
    localparam logic [3:0] REG_ARR    = 4'd9;
    localparam logic [3:0] REG_CMP0   = 4'd10;

    // internal control bits
    localparam int CB_EN      = 0;
    localparam int CB_ONESHOT = 1;
    localparam int CB_DOWN    = 2;
    localparam int CB_ARPE    = 3;

    // control register bus bit positions
    localparam int CTRL_EN_POS      = 0;
    localparam int CTRL_ONESHOT_POS = 3;
    localparam int CTRL_DOWN_POS    = 4;
    localparam int CTRL_ARPE_POS    = 7;

    // per-channel mode byte
    localparam int CCR_PRELOAD_POS = 3;
    localparam int OCM_LSB         = 4;

    localparam logic [2:0] OCM_FROZEN     = 3'd0;
    localparam logic [2:0] OCM_ACTIVE     = 3'd1;
    localparam logic [2:0] OCM_INACTIVE   = 3'd2;
    localparam logic [2:0] OCM_TOGGLE     = 3'd3;
    localparam logic [2:0] OCM_FORCE_LOW  = 3'd4;
    localparam logic [2:0] OCM_FORCE_HIGH = 3'd5;
    localparam logic [2:0] OCM_PWM1       = 3'd6;
    localparam logic [2:0] OCM_PWM2       = 3'd7;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  reg_index;
        logic [15:0] write_value;
    } cmd_item_t;

    typedef struct packed {
        logic [15:0] read_value;
        logic        irq;
        logic [3:0]  pwm_outputs;
    } res_item_t;

    // counter context seen by each compare channel
    typedef struct packed {
        logic step;
        logic down;
        cnt_t count;
    } cnt_ctx_t;

    function automatic cnt_t bus_to_cnt(input logic [15:0] v);
        logic [COUNT_WIDTH+15:0] tmp;
        tmp = {{COUNT_WIDTH{1'b0}}, v};
        return tmp[COUNT_WIDTH-1:0];
    endfunction

    function automatic logic [15:0] cnt_to_bus(input cnt_t v);
        logic [COUNT_WIDTH+15:0] tmp;
        tmp = {16'd0, v};
        return tmp[15:0];
    endfunction

endpackage

FILE: design/gpt_chan.sv
module gpt_chan
    import gpt_pkg::*;
(
    input  cnt_ctx_t   ctx,
    input  logic [7:0] mode_byte,
    input  cnt_t       cmp,
    input  logic       ref_cur,
    output logic       ref_nxt
);

    logic [2:0] mode;
    logic       match;
    logic       act;

    assign mode  = mode_byte[OCM_LSB +: 3];
    assign match = ctx.step && (ctx.count == cmp);
    assign act   = ctx.down ? (ctx.count <= cmp) : (ctx.count < cmp);

    always_comb
    begin
        ref_nxt = ref_cur;
        case (mode)
            OCM_ACTIVE:
            begin
                if (match)
                begin
                    ref_nxt = 1'b1;
                end
            end
            OCM_INACTIVE:
            begin
                if (match)
                begin
                    ref_nxt = 1'b0;
                end
            end
            OCM_TOGGLE:
            begin
                if (match)
                begin
                    ref_nxt = ~ref_cur;
                end
            end
            OCM_FORCE_LOW:  ref_nxt = 1'b0;
            OCM_FORCE_HIGH: ref_nxt = 1'b1;
            OCM_PWM1:       ref_nxt = act;
            OCM_PWM2:       ref_nxt = ~act;
            default:        ref_nxt = ref_cur;
        endcase
    end

endmodule

FILE: design/gpt_core.sv
module gpt_core
    import gpt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      go,
    input  cmd_item_t item,
    output res_item_t result
);

    logic [3:0]          ctrl_reg, ctrl_next;
    logic                irq_en_reg, irq_en_next;
    logic                flag_reg, flag_next;
    cnt_t                count_reg, count_next;
    logic [15:0]         psc_cnt_reg, psc_cnt_next;
    logic [15:0]         psc_pre_reg, psc_pre_next;
    logic [15:0]         psc_act_reg, psc_act_next;
    cnt_t                arr_pre_reg, arr_pre_next;
    cnt_t                arr_act_reg, arr_act_next;
    cnt_t                ccr_pre_reg [CHANNELS];
    cnt_t                ccr_pre_next [CHANNELS];
    cnt_t                ccr_act_reg [CHANNELS];
    cnt_t                ccr_act_next [CHANNELS];
    logic [15:0]         mode_reg [2];
    logic [15:0]         mode_next [2];
    logic [15:0]         chen_reg, chen_next;
    logic [CHANNELS-1:0] ref_reg, ref_next;

    logic        step;
    logic        ovf;
    logic        upd;
    logic [15:0] rd;
    logic [3:0]  pwm;
    cnt_t        eff_arr;
    cnt_ctx_t    ctx;
    logic [7:0]  chan_mode [CHANNELS];
    cnt_t        chan_cmp [CHANNELS];

    always_comb
    begin
        ctrl_next    = ctrl_reg;
        irq_en_next  = irq_en_reg;
        flag_next    = flag_reg;
        count_next   = count_reg;
        psc_cnt_next = psc_cnt_reg;
        psc_pre_next = psc_pre_reg;
        psc_act_next = psc_act_reg;
        arr_pre_next = arr_pre_reg;
        arr_act_next = arr_act_reg;
        ccr_pre_next = ccr_pre_reg;
        ccr_act_next = ccr_act_reg;
        mode_next    = mode_reg;
        chen_next    = chen_reg;
        step         = 1'b0;
        ovf          = 1'b0;
        upd          = 1'b0;
        rd           = 16'd0;
        eff_arr      = ctrl_reg[CB_ARPE] ? arr_act_reg : arr_pre_reg;

        if (item.command == CMD_TICK)
        begin
            if (ctrl_reg[CB_EN])
            begin
                if (psc_cnt_reg >= psc_act_reg)
                begin
                    psc_cnt_next = 16'd0;
                    step         = 1'b1;
                end
                else
                begin
                    psc_cnt_next = psc_cnt_reg + 16'd1;
                end
            end
            if (step)
            begin
                if (ctrl_reg[CB_DOWN])
                begin
                    if (count_reg == '0)
                    begin
                        ovf = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg - cnt_t'(1);
                    end
                end
                else
                begin
                    if (count_reg == eff_arr)
                    begin
                        ovf = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + cnt_t'(1);
                    end
                end
            end
            if (ovf)
            begin
                upd = 1'b1;
                if (ctrl_reg[CB_ONESHOT])
                begin
                    ctrl_next[CB_EN] = 1'b0;
                end
            end
        end
        else if (item.command == CMD_WRITE)
        begin
            case (item.reg_index)
                REG_CTRL:
                begin
                    ctrl_next[CB_EN]      = item.write_value[CTRL_EN_POS];
                    ctrl_next[CB_ONESHOT] = item.write_value[CTRL_ONESHOT_POS];
                    ctrl_next[CB_DOWN]    = item.write_value[CTRL_DOWN_POS];
                    ctrl_next[CB_ARPE]    = item.write_value[CTRL_ARPE_POS];
                end
                REG_IRQ_EN: irq_en_next = item.write_value[0];
                REG_STATUS:
                begin
                    // write-zero-to-clear
                    if (!item.write_value[0])
                    begin
                        flag_next = 1'b0;
                    end
                end
                REG_EVENT:  upd = item.write_value[0];
                REG_MODE0:  mode_next[0] = item.write_value;
                REG_MODE1:  mode_next[1] = item.write_value;
                REG_CHEN:   chen_next = item.write_value;
                REG_COUNT:  count_next = bus_to_cnt(item.write_value);
                REG_PSC:    psc_pre_next = item.write_value;
                REG_ARR:    arr_pre_next = bus_to_cnt(item.write_value);
                default:
                begin
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        if (item.reg_index == REG_CMP0 + 4'(c))
                        begin
                            ccr_pre_next[c] = bus_to_cnt(item.write_value);
                        end
                    end
                end
            endcase
        end
        else if (item.command == CMD_READ)
        begin
            case (item.reg_index)
                REG_CTRL:
                begin
                    rd[CTRL_EN_POS]      = ctrl_reg[CB_EN];
                    rd[CTRL_ONESHOT_POS] = ctrl_reg[CB_ONESHOT];
                    rd[CTRL_DOWN_POS]    = ctrl_reg[CB_DOWN];
                    rd[CTRL_ARPE_POS]    = ctrl_reg[CB_ARPE];
                end
                REG_IRQ_EN: rd[0] = irq_en_reg;
                REG_STATUS: rd[0] = flag_reg;
                REG_MODE0:  rd = mode_reg[0];
                REG_MODE1:  rd = mode_reg[1];
                REG_CHEN:   rd = chen_reg;
                REG_COUNT:  rd = cnt_to_bus(count_reg);
                REG_PSC:    rd = psc_pre_reg;
                REG_ARR:    rd = cnt_to_bus(arr_pre_reg);
                default:
                begin
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        if (item.reg_index == REG_CMP0 + 4'(c))
                        begin
                            rd = cnt_to_bus(ccr_pre_reg[c]);
                        end
                    end
                end
            endcase
        end

        // update event: shadow copy, prescaler and counter restart, flag set
        if (upd)
        begin
            psc_act_next = psc_pre_reg;
            arr_act_next = arr_pre_reg;
            ccr_act_next = ccr_pre_reg;
            psc_cnt_next = 16'd0;
            flag_next    = 1'b1;
            count_next   = ctrl_reg[CB_DOWN] ? arr_pre_reg : '0;
        end
    end

    assign ctx.step  = step;
    assign ctx.down  = ctrl_next[CB_DOWN];
    assign ctx.count = count_next;

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_chan
        localparam int MI = c / 2;
        localparam int MO = (c % 2) * 8;

        assign chan_mode[c] = mode_next[MI][MO +: 8];
        assign chan_cmp[c]  = chan_mode[c][CCR_PRELOAD_POS] ? ccr_act_next[c]
                                                            : ccr_pre_next[c];

        gpt_chan u_chan (
            .ctx       (ctx),
            .mode_byte (chan_mode[c]),
            .cmp       (chan_cmp[c]),
            .ref_cur   (ref_reg[c]),
            .ref_nxt   (ref_next[c])
        );
    end

    always_comb
    begin
        pwm = 4'd0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            pwm[c] = chen_next[4*c] & (ref_next[c] ^ chen_next[4*c+1]);
        end
    end

    assign result.read_value  = rd;
    assign result.irq         = flag_next & irq_en_next;
    assign result.pwm_outputs = pwm;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg    <= '0;
            irq_en_reg  <= 1'b0;
            flag_reg    <= 1'b0;
            count_reg   <= '0;
            psc_cnt_reg <= '0;
            psc_pre_reg <= '0;
            psc_act_reg <= '0;
            arr_pre_reg <= '1;
            arr_act_reg <= '1;
            for (int c = 0; c < CHANNELS; c++)
            begin
                ccr_pre_reg[c] <= '0;
                ccr_act_reg[c] <= '0;
            end
            mode_reg[0] <= '0;
            mode_reg[1] <= '0;
            chen_reg    <= '0;
            ref_reg     <= '0;
        end
        else if (go)
        begin
            ctrl_reg    <= ctrl_next;
            irq_en_reg  <= irq_en_next;
            flag_reg    <= flag_next;
            count_reg   <= count_next;
            psc_cnt_reg <= psc_cnt_next;
            psc_pre_reg <= psc_pre_next;
            psc_act_reg <= psc_act_next;
            arr_pre_reg <= arr_pre_next;
            arr_act_reg <= arr_act_next;
            ccr_pre_reg <= ccr_pre_next;
            ccr_act_reg <= ccr_act_next;
            mode_reg    <= mode_next;
            chen_reg    <= chen_next;
            ref_reg     <= ref_next;
        end
    end

endmodule

FILE: design/general_purpose_timer_pwm_unit.sv
// channel   direction  valid      stall      payload
// cmd       in         cmd_valid  cmd_stall  cmd_data (cmd_item_t)
// res       out        res_valid  res_stall  res_data (res_item_t)
//
// one request per cycle sustained while res_stall is low: a request is held in the input
// register, then the timer state and the result are updated as it moves on into the output
// register, where the result waits until it is taken.
// the input and output registers keep the two sides apart; res_stall holds the
// result and backs up into cmd_stall only once both registers are full.
// rst_n clears all timer state and empties both registers.
module general_purpose_timer_pwm_unit
    import gpt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd_data,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res_data
);

    logic      in_valid_reg, in_valid_next;
    cmd_item_t in_item_reg;
    logic      out_valid_reg, out_valid_next;
    res_item_t out_item_reg;
    logic      move;
    logic      take;
    res_item_t core_res;

    assign move      = in_valid_reg && (!out_valid_reg || !res_stall);
    assign cmd_stall = in_valid_reg && !move;
    assign take      = cmd_valid && !cmd_stall;

    assign in_valid_next  = take || (in_valid_reg && !move);
    assign out_valid_next = move || (out_valid_reg && res_stall);

    gpt_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (move),
        .item   (in_item_reg),
        .result (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg <= cmd_data;
        end
        if (move)
        begin
            out_item_reg <= core_res;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_item_reg;

endmodule

FILE: design/gpt_checker.sv
module gpt_checker
    import gpt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cmd_valid,
    input logic      cmd_stall,
    input cmd_item_t cmd_data,
    input logic      res_valid,
    input logic      res_stall,
    input res_item_t res_data
);

    // held result stays put
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // stalled request stays put
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd_data))
        else $error("request changed while stalled");

    // with the output register empty the input side never stalls
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> !cmd_stall)
        else $error("request stalled with empty output");

    // an accepted request reaches the output when the consumer takes
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) ##1 !res_stall |=> res_valid)
        else $error("accepted request did not reach the output");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !res_valid)
        else $error("result valid during reset");

endmodule

bind general_purpose_timer_pwm_unit gpt_checker u_gpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);
